// ----- rtl/core/pooling_2d_max_average_unit_defines.svh -----
// assertion macros shared by the pooling unit
`ifndef POOLING_2D_MAX_AVERAGE_UNIT_DEFINES_SVH
`define POOLING_2D_MAX_AVERAGE_UNIT_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define POOL_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define POOL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pool2d_pkg.sv -----
// shared types and constants of the pooling unit
package pool2d_pkg;

    // default sizes
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_KERNEL = 16;
    localparam int DEF_PIXEL_BITS = 16;

    // largest effective stride
    localparam int MAX_STRIDE = 16;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int POS_W     = 7;
    localparam int ARG_W     = 13;
    localparam int COUNT_W   = 9;
    localparam int KREG_W    = 5;
    localparam int PREG_W    = 4;
    localparam int IREG_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 7;

    // opcodes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_MAX   = 2'd1;
    localparam logic [OP_W-1:0] OP_AVG   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_H = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_W = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_R = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_R    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_C    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_H  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_W  = 3'd7;

    // steps of the output size divider
    localparam int SIZE_STEPS = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIZE,
        ST_CHECK,
        ST_WINDOW,
        ST_SCAN,
        ST_DRAIN,
        ST_RESOLVE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic size_step;
        logic size_fix;
        logic window;
        logic scan_step;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic step_last;
        logic scan_go;
        logic scan_last;
        logic avg_go;
        logic out_space;
    } status_t;

endpackage

// ----- rtl/core/pool2d_ifs.sv -----
// request and response channel interfaces
interface pool2d_req_if #(
    parameter int PIXEL_BITS = pool2d_pkg::DEF_PIXEL_BITS
);
    logic                                valid;
    logic                                ready;
    logic [pool2d_pkg::OP_W-1:0]         opcode;
    logic [pool2d_pkg::POS_W-1:0]        row;
    logic [pool2d_pkg::POS_W-1:0]        col;
    logic signed [PIXEL_BITS-1:0]        pixel;

    modport source (output valid, opcode, row, col, pixel, input ready);
    modport sink   (input valid, opcode, row, col, pixel, output ready);
endinterface

interface pool2d_rsp_if #(
    parameter int PIXEL_BITS = pool2d_pkg::DEF_PIXEL_BITS
);
    logic                                valid;
    logic                                ready;
    logic signed [PIXEL_BITS-1:0]        pooled_value;
    logic signed [pool2d_pkg::ARG_W-1:0] argmax_index;
    logic [pool2d_pkg::COUNT_W-1:0]      window_count;
    logic                                in_range;
    logic [pool2d_pkg::POS_W-1:0]        out_height;
    logic [pool2d_pkg::POS_W-1:0]        out_width;

    modport source (output valid, pooled_value, argmax_index, window_count, in_range,
                    out_height, out_width, input ready);
    modport sink   (input valid, pooled_value, argmax_index, window_count, in_range,
                    out_height, out_width, output ready);
endinterface

// ----- rtl/core/pool2d_ctrl.sv -----
// sequencing state machine of the pooling unit
module pool2d_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  pool2d_pkg::status_t status,
    output pool2d_pkg::cmd_t    cmd
);

    pool2d_pkg::state_t state_reg;
    pool2d_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pool2d_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            pool2d_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = pool2d_pkg::ST_SIZE;
                end
            end
            pool2d_pkg::ST_SIZE:
            begin
                cmd.size_step = 1'b1;
                if (status.step_last)
                begin
                    state_next = pool2d_pkg::ST_CHECK;
                end
            end
            pool2d_pkg::ST_CHECK:
            begin
                cmd.size_fix = 1'b1;
                state_next   = pool2d_pkg::ST_WINDOW;
            end
            pool2d_pkg::ST_WINDOW:
            begin
                cmd.window = 1'b1;
                state_next = pool2d_pkg::ST_SCAN;
            end
            pool2d_pkg::ST_SCAN:
            begin
                if (!status.scan_go)
                begin
                    state_next = pool2d_pkg::ST_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (status.scan_last)
                    begin
                        state_next = pool2d_pkg::ST_DRAIN;
                    end
                end
            end
            pool2d_pkg::ST_DRAIN:
            begin
                state_next = pool2d_pkg::ST_RESOLVE;
            end
            pool2d_pkg::ST_RESOLVE:
            begin
                if (status.avg_go)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = pool2d_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = pool2d_pkg::ST_DONE;
                end
            end
            pool2d_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.step_last)
                begin
                    state_next = pool2d_pkg::ST_DONE;
                end
            end
            pool2d_pkg::ST_DONE:
            begin
                if (status.out_space)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = pool2d_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pool2d_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/pool2d_dp.sv -----
// datapath: config registers, pixel memory, window scan, accumulators, dividers
module pool2d_dp #(
    parameter int MAX_HEIGHT = pool2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = pool2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = pool2d_pkg::DEF_MAX_KERNEL,
    parameter int PIXEL_BITS = pool2d_pkg::DEF_PIXEL_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pool2d_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pool2d_pkg::CFG_DAT_W-1:0]      cfg_data,
    input  logic [pool2d_pkg::OP_W-1:0]           req_opcode,
    input  logic [pool2d_pkg::POS_W-1:0]          req_row,
    input  logic [pool2d_pkg::POS_W-1:0]          req_col,
    input  logic signed [PIXEL_BITS-1:0]          req_pixel,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output logic signed [PIXEL_BITS-1:0]          rsp_pooled_value,
    output logic signed [pool2d_pkg::ARG_W-1:0]   rsp_argmax_index,
    output logic [pool2d_pkg::COUNT_W-1:0]        rsp_window_count,
    output logic                                  rsp_in_range,
    output logic [pool2d_pkg::POS_W-1:0]          rsp_out_height,
    output logic [pool2d_pkg::POS_W-1:0]          rsp_out_width,
    input  pool2d_pkg::cmd_t                      cmd,
    output pool2d_pkg::status_t                   status
);

    localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int MAG_W  = PIXEL_BITS - 1 + CNT_W;
    localparam int SUM_W  = MAG_W + 1;
    localparam int STEP_W = $clog2(MAG_W + 1);
    localparam int KW     = pool2d_pkg::KREG_W;
    localparam int PW     = pool2d_pkg::PREG_W;
    localparam int IW     = pool2d_pkg::IREG_W;
    localparam int PSW    = pool2d_pkg::POS_W;

    // output size with the last-window clip, from the divided magnitude
    function automatic logic [PSW-1:0] size_fix(
        input logic [7:0]    quo,
        input logic          neg,
        input logic [IW-1:0] size,
        input logic [KW-1:0] s,
        input logic [KW-1:0] p
    );
        logic signed [9:0]  qs;
        logic signed [9:0]  outv;
        logic signed [15:0] reach;
        qs    = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
        outv  = qs + 10'sd1;
        reach = 16'(qs) * $signed({11'b0, s});
        if (p != '0 && outv >= 10'sd1 && reach >= $signed(16'(size) + 16'(p)))
        begin
            outv = outv - 10'sd1;
        end
        if (outv < 10'sd0)
        begin
            outv = 10'sd0;
        end
        return PSW'(outv);
    endfunction

    // configuration registers
    logic [KW-1:0] kh_reg, kw_reg, sr_reg, sc_reg;
    logic [PW-1:0] pr_reg, pc_reg;
    logic [IW-1:0] ih_reg, iw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kh_reg <= KW'(2);
            kw_reg <= KW'(2);
            sr_reg <= KW'(2);
            sc_reg <= KW'(2);
            pr_reg <= '0;
            pc_reg <= '0;
            ih_reg <= IW'(64);
            iw_reg <= IW'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pool2d_pkg::REG_KERNEL_H: kh_reg <= cfg_data[KW-1:0];
                pool2d_pkg::REG_KERNEL_W: kw_reg <= cfg_data[KW-1:0];
                pool2d_pkg::REG_STRIDE_R: sr_reg <= cfg_data[KW-1:0];
                pool2d_pkg::REG_STRIDE_C: sc_reg <= cfg_data[KW-1:0];
                pool2d_pkg::REG_PAD_R:    pr_reg <= cfg_data[PW-1:0];
                pool2d_pkg::REG_PAD_C:    pc_reg <= cfg_data[PW-1:0];
                pool2d_pkg::REG_IMAGE_H:  ih_reg <= cfg_data[IW-1:0];
                pool2d_pkg::REG_IMAGE_W:  iw_reg <= cfg_data[IW-1:0];
                default:                  ih_reg <= ih_reg;
            endcase
        end
    end

    // effective configuration after clamping
    logic [KW-1:0] kh, kw, sr, sc, pr, pc;
    logic [IW-1:0] ih, iw;

    always_comb
    begin
        kh = (kh_reg == '0) ? KW'(1) : ((int'(kh_reg) > MAX_KERNEL) ? KW'(MAX_KERNEL) : kh_reg);
        kw = (kw_reg == '0) ? KW'(1) : ((int'(kw_reg) > MAX_KERNEL) ? KW'(MAX_KERNEL) : kw_reg);
        sr = (sr_reg == '0) ? KW'(1)
           : ((int'(sr_reg) > pool2d_pkg::MAX_STRIDE) ? KW'(pool2d_pkg::MAX_STRIDE) : sr_reg);
        sc = (sc_reg == '0) ? KW'(1)
           : ((int'(sc_reg) > pool2d_pkg::MAX_STRIDE) ? KW'(pool2d_pkg::MAX_STRIDE) : sc_reg);
        pr = (KW'(pr_reg) >= kh) ? kh - KW'(1) : KW'(pr_reg);
        pc = (KW'(pc_reg) >= kw) ? kw - KW'(1) : KW'(pc_reg);
        ih = (ih_reg == '0) ? IW'(1) : ((int'(ih_reg) > MAX_HEIGHT) ? IW'(MAX_HEIGHT) : ih_reg);
        iw = (iw_reg == '0) ? IW'(1) : ((int'(iw_reg) > MAX_WIDTH) ? IW'(MAX_WIDTH) : iw_reg);
    end

    // latched item
    logic [pool2d_pkg::OP_W-1:0] op_reg;
    logic [PSW-1:0]              row_reg, col_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= req_opcode;
            row_reg <= req_row;
            col_reg <= req_col;
        end
    end

    // pixel memory, written on accept and read by the scan
    logic signed [PIXEL_BITS-1:0] mem [DEPTH];
    logic signed [PIXEL_BITS-1:0] rd_data_reg;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic [PSW-1:0]               h_reg, w_reg;

    assign wr_en = cmd.accept && req_opcode == pool2d_pkg::OP_WRITE
                   && int'(req_row) < MAX_HEIGHT && int'(req_col) < MAX_WIDTH;
    assign wr_addr = AW'(int'(req_row) * MAX_WIDTH + int'(req_col));
    assign rd_addr = AW'(int'(h_reg) * MAX_WIDTH + int'(w_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req_pixel;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // shared step counter for both dividers
    logic [STEP_W-1:0] step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.accept)
        begin
            step_reg <= STEP_W'(pool2d_pkg::SIZE_STEPS);
        end
        else if (cmd.div_load)
        begin
            step_reg <= STEP_W'(MAG_W);
        end
        else if (cmd.size_step || cmd.div_step)
        begin
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    // output size: restoring division of the padded span by the stride, per axis
    logic [7:0]        rq_reg, cq_reg;
    logic [KW-1:0]     rr_reg, cr_reg;
    logic              rneg_reg, cneg_reg;
    logic signed [9:0] rn, cn;
    logic [KW:0]       rt, ct;
    logic [PSW-1:0]    oh_reg, ow_reg;

    assign rn = $signed(10'(ih)) + $signed(10'(pr) << 1) - $signed(10'(kh));
    assign cn = $signed(10'(iw)) + $signed(10'(pc) << 1) - $signed(10'(kw));
    assign rt = {rr_reg, rq_reg[7]};
    assign ct = {cr_reg, cq_reg[7]};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rneg_reg <= rn < 0;
            cneg_reg <= cn < 0;
            rq_reg   <= (rn < 0) ? 8'(-rn) : 8'(rn + $signed(10'(sr)) - 10'sd1);
            cq_reg   <= (cn < 0) ? 8'(-cn) : 8'(cn + $signed(10'(sc)) - 10'sd1);
            rr_reg   <= '0;
            cr_reg   <= '0;
        end
        else if (cmd.size_step)
        begin
            rq_reg <= {rq_reg[6:0], rt >= {1'b0, sr}};
            cq_reg <= {cq_reg[6:0], ct >= {1'b0, sc}};
            rr_reg <= (rt >= {1'b0, sr}) ? KW'(rt - {1'b0, sr}) : KW'(rt);
            cr_reg <= (ct >= {1'b0, sc}) ? KW'(ct - {1'b0, sc}) : KW'(ct);
        end
        if (cmd.size_fix)
        begin
            oh_reg <= size_fix(rq_reg, rneg_reg, ih, sr, pr);
            ow_reg <= size_fix(cq_reg, cneg_reg, iw, sc, pc);
        end
    end

    // window bounds clipped to the image
    logic [11:0]        row_prod, col_prod;
    logic signed [13:0] hs, ws, he, we, hs0, ws0;
    logic               is_query;

    assign is_query = op_reg == pool2d_pkg::OP_MAX || op_reg == pool2d_pkg::OP_AVG;
    assign row_prod = 12'(row_reg) * 12'(sr);
    assign col_prod = 12'(col_reg) * 12'(sc);

    always_comb
    begin
        hs  = $signed({2'b00, row_prod}) - $signed(14'(pr));
        ws  = $signed({2'b00, col_prod}) - $signed(14'(pc));
        he  = (hs + $signed(14'(kh)) < $signed(14'(ih))) ? hs + $signed(14'(kh))
                                                        : $signed(14'(ih));
        we  = (ws + $signed(14'(kw)) < $signed(14'(iw))) ? ws + $signed(14'(kw))
                                                        : $signed(14'(iw));
        hs0 = (hs < 0) ? 14'sd0 : hs;
        ws0 = (ws < 0) ? 14'sd0 : ws;
    end

    // scan walker
    logic           inr_reg, go_reg;
    logic [PSW-1:0] ws_reg, he_reg, we_reg;
    logic           w_wrap;

    assign w_wrap = (8'(w_reg) + 8'd1) == 8'(we_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.window)
        begin
            inr_reg <= is_query && row_reg < oh_reg && col_reg < ow_reg;
            go_reg  <= is_query && row_reg < oh_reg && col_reg < ow_reg
                       && hs0 < he && ws0 < we;
            h_reg   <= PSW'(hs0);
            w_reg   <= PSW'(ws0);
            ws_reg  <= PSW'(ws0);
            he_reg  <= PSW'(he);
            we_reg  <= PSW'(we);
        end
        else if (cmd.scan_step)
        begin
            if (w_wrap)
            begin
                w_reg <= ws_reg;
                h_reg <= h_reg + PSW'(1);
            end
            else
            begin
                w_reg <= w_reg + PSW'(1);
            end
        end
    end

    // read tag follows the memory latency
    logic           rd_valid_reg;
    logic [PSW-1:0] tag_h_reg, tag_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            tag_h_reg <= h_reg;
            tag_w_reg <= w_reg;
        end
    end

    // accumulators: sum, count, first strict maximum
    localparam int ARG_W_L = pool2d_pkg::ARG_W;
    logic signed [SUM_W-1:0]      sum_reg;
    logic [CNT_W-1:0]             count_reg;
    logic signed [PIXEL_BITS-1:0] best_reg;
    logic signed [ARG_W_L-1:0]    arg_reg;
    logic                         have_reg;
    logic [ARG_W_L-1:0]           raster_idx;

    assign raster_idx = ARG_W_L'(14'(tag_h_reg) * 14'(iw) + 14'(tag_w_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.window)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            have_reg  <= 1'b0;
            best_reg  <= '0;
            arg_reg   <= '1;
        end
        else if (rd_valid_reg)
        begin
            sum_reg   <= sum_reg + SUM_W'(rd_data_reg);
            count_reg <= count_reg + CNT_W'(1);
            if (!have_reg || rd_data_reg > best_reg)
            begin
                best_reg <= rd_data_reg;
                arg_reg  <= $signed(raster_idx);
                have_reg <= 1'b1;
            end
        end
    end

    // mean: restoring division of the sum magnitude by the count
    logic [MAG_W-1:0] dq_reg;
    logic [CNT_W-1:0] dr_reg;
    logic             dneg_reg;
    logic [CNT_W:0]   dt;
    logic             dge;

    assign dt  = {dr_reg, dq_reg[MAG_W-1]};
    assign dge = dt >= {1'b0, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dneg_reg <= sum_reg < 0;
            dq_reg   <= (sum_reg < 0) ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
            dr_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg <= {dq_reg[MAG_W-2:0], dge};
            dr_reg <= dge ? CNT_W'(dt - {1'b0, count_reg}) : CNT_W'(dt);
        end
    end

    // result register
    logic                         out_valid_reg;
    logic signed [PIXEL_BITS-1:0] val_reg;
    logic signed [ARG_W_L-1:0]    oarg_reg;
    logic [pool2d_pkg::COUNT_W-1:0] ocnt_reg;
    logic                         oinr_reg;
    logic [PSW-1:0]               ooh_reg, oow_reg;
    logic signed [PIXEL_BITS-1:0] val_next;
    logic signed [ARG_W_L-1:0]    arg_next;
    logic [MAG_W-1:0]             mean_mag;

    assign mean_mag = dneg_reg ? -dq_reg : dq_reg;

    always_comb
    begin
        val_next = {1'b1, {(PIXEL_BITS-1){1'b0}}};
        arg_next = '1;
        if (inr_reg && count_reg != '0)
        begin
            if (op_reg == pool2d_pkg::OP_MAX)
            begin
                val_next = best_reg;
                arg_next = arg_reg;
            end
            else
            begin
                val_next = $signed(mean_mag[PIXEL_BITS-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            val_reg  <= val_next;
            oarg_reg <= arg_next;
            ocnt_reg <= pool2d_pkg::COUNT_W'(count_reg);
            oinr_reg <= inr_reg;
            ooh_reg  <= oh_reg;
            oow_reg  <= ow_reg;
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_pooled_value = val_reg;
    assign rsp_argmax_index = oarg_reg;
    assign rsp_window_count = ocnt_reg;
    assign rsp_in_range     = oinr_reg;
    assign rsp_out_height   = ooh_reg;
    assign rsp_out_width    = oow_reg;

    // status to the controller
    always_comb
    begin
        status.step_last = step_reg == STEP_W'(1);
        status.scan_go   = go_reg;
        status.scan_last = w_wrap && (8'(h_reg) + 8'd1) == 8'(he_reg);
        status.avg_go    = op_reg == pool2d_pkg::OP_AVG && inr_reg && count_reg != '0;
        status.out_space = !out_valid_reg || rsp_ready;
    end

endmodule

// ----- rtl/core/pooling_2d_max_average_unit.sv -----
// Max and average pooling over one stored channel plane.
// The req channel carries one item per beat: a write stores a pixel at
// (row, col); a max or average query names an output position and the
// unit clips the padded, strided window to the image. The rsp channel
// returns exactly one beat for every req beat, in order, carrying the
// pooled value, argmax raster index, window pixel count, range flag and
// the current pooled output size. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data); the user must use it only while the
// unit is idle, which the unit does not enforce. One item is in work
// at a time. Every item passes the 8-step output size divider; a query
// then reads its window, at most the kernel area, through the single
// memory read port (one pixel a cycle), and an average query adds a
// bit-serial divide of the window sum by the window pixel count.
// Reset restores the register defaults and empties the result register;
// the pixel memory holds no reset value and must be written before use.
// A finished result waits in the result register while the next item is
// accepted; if rsp stalls, the following result waits until it drains.
module pooling_2d_max_average_unit #(
    parameter int MAX_HEIGHT = pool2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = pool2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = pool2d_pkg::DEF_MAX_KERNEL,
    parameter int PIXEL_BITS = pool2d_pkg::DEF_PIXEL_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pool2d_req_if.sink                       req,
    pool2d_rsp_if.source                     rsp,
    input  logic                             cfg_we,
    input  logic [pool2d_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pool2d_pkg::CFG_DAT_W-1:0] cfg_data
);

`include "pooling_2d_max_average_unit_defines.svh"

    pool2d_pkg::cmd_t    cmd;
    pool2d_pkg::status_t status;
    logic                req_ready;

    // controller
    pool2d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    assign req.ready = req_ready;

    // datapath
    pool2d_dp #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_opcode       (req.opcode),
        .req_row          (req.row),
        .req_col          (req.col),
        .req_pixel        (req.pixel),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_pooled_value (rsp.pooled_value),
        .rsp_argmax_index (rsp.argmax_index),
        .rsp_window_count (rsp.window_count),
        .rsp_in_range     (rsp.in_range),
        .rsp_out_height   (rsp.out_height),
        .rsp_out_width    (rsp.out_width),
        .cmd              (cmd),
        .status           (status)
    );

    // checks
    `POOL_ASSERT_NEXT(a_one_item_in_work, req.valid && req.ready, !req.ready, "item overlap")
    `POOL_ASSERT_NOW(a_argmax_needs_window, rsp.valid && rsp.argmax_index != '1, rsp.in_range && rsp.window_count != '0, "argmax without window")
    `POOL_ASSERT_NOW(a_out_of_range_empty, rsp.valid && !rsp.in_range, rsp.window_count == '0, "count outside range")

endmodule

// ----- test/pooling_2d_max_average_unit_tb.sv -----
// testbench for the max and average pooling unit, with a self-checking predictor
module pooling_2d_max_average_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W      = pool2d_pkg::OP_W;
    localparam int POS_W     = pool2d_pkg::POS_W;
    localparam int ARG_W     = pool2d_pkg::ARG_W;
    localparam int COUNT_W   = pool2d_pkg::COUNT_W;
    localparam int CFG_IDX_W = pool2d_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = pool2d_pkg::CFG_DAT_W;
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;
    localparam int STORE_H = 64;
    localparam int STORE_W = 64;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic signed [15:0]        value;
        logic signed [ARG_W-1:0]   argmax;
        logic [COUNT_W-1:0]        count;
        logic                      in_range;
        logic [POS_W-1:0]          out_h;
        logic [POS_W-1:0]          out_w;
    } pool_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    pool2d_req_if req_ch ();
    pool2d_rsp_if rsp_ch ();

    pooling_2d_max_average_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the plane and the registers
    logic signed [15:0] image_mem [STORE_H*STORE_W];
    bit                 img_written [STORE_H*STORE_W];
    int unsigned        reg_file [8];

    pool_result_t pending_results [$];
    int  error_count = 0;
    int  items_sent = 0;
    int  beats_checked = 0;
    int  max_queries = 0;
    int  avg_queries = 0;
    int  hold_request = 0;
    bit  quiet = 1'b0;
    longint cycle_count = 0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int pooled_dim(int size, int k, int s, int p);
        int n;
        int q;
        int o;
        n = size + 2 * p - k;
        q = (n >= 0) ? (n + s - 1) / s : -((-n) / s);
        o = q + 1;
        if (p > 0 && o >= 1 && (o - 1) * s >= size + p)
            o--;
        return (o < 0) ? 0 : o;
    endfunction

    // effective geometry from the shadow registers
    task automatic calc_geometry(output int kh, output int kw, output int sr, output int sc,
                                 output int pr, output int pc, output int ih, output int iw,
                                 output int oh, output int ow);
        kh = clamp_int(reg_file[pool2d_pkg::REG_KERNEL_H], 1, 16);
        kw = clamp_int(reg_file[pool2d_pkg::REG_KERNEL_W], 1, 16);
        sr = clamp_int(reg_file[pool2d_pkg::REG_STRIDE_R], 1, 16);
        sc = clamp_int(reg_file[pool2d_pkg::REG_STRIDE_C], 1, 16);
        pr = clamp_int(reg_file[pool2d_pkg::REG_PAD_R], 0, kh - 1);
        pc = clamp_int(reg_file[pool2d_pkg::REG_PAD_C], 0, kw - 1);
        ih = clamp_int(reg_file[pool2d_pkg::REG_IMAGE_H], 1, STORE_H);
        iw = clamp_int(reg_file[pool2d_pkg::REG_IMAGE_W], 1, STORE_W);
        oh = pooled_dim(ih, kh, sr, pr);
        ow = pooled_dim(iw, kw, sc, pc);
    endtask

    // expected result of one beat, updates the shadow plane on writes
    task automatic predict_pool(input logic [OP_W-1:0] op, input int r, input int c,
                                input logic signed [15:0] pix, output pool_result_t res);
        int kh, kw, sr, sc, pr, pc, ih, iw, oh, ow;
        int hs, ws, he, we, cnt;
        longint sum, best, arg, mag, v;
        bit have;
        calc_geometry(kh, kw, sr, sc, pr, pc, ih, iw, oh, ow);
        cnt = 0;
        sum = 0;
        best = 0;
        arg = -1;
        have = 1'b0;
        res.value = 16'sh8000;
        res.in_range = 1'b0;
        if (op == pool2d_pkg::OP_WRITE)
        begin
            if (r < STORE_H && c < STORE_W)
            begin
                image_mem[r*STORE_W + c] = pix;
                img_written[r*STORE_W + c] = 1'b1;
            end
        end
        else if ((op == pool2d_pkg::OP_MAX || op == pool2d_pkg::OP_AVG) && r < oh && c < ow)
        begin
            res.in_range = 1'b1;
            hs = r * sr - pr;
            ws = c * sc - pc;
            he = (hs + kh < ih) ? hs + kh : ih;
            we = (ws + kw < iw) ? ws + kw : iw;
            if (hs < 0)
                hs = 0;
            if (ws < 0)
                ws = 0;
            for (int h = hs; h < he; h++)
            begin
                for (int w = ws; w < we; w++)
                begin
                    v = image_mem[h*STORE_W + w];
                    cnt++;
                    sum += v;
                    if (!have || v > best)
                    begin
                        best = v;
                        arg = h * iw + w;
                        have = 1'b1;
                    end
                end
            end
            if (cnt > 0)
            begin
                if (op == pool2d_pkg::OP_MAX)
                    res.value = best[15:0];
                else
                begin
                    mag = ((sum < 0) ? -sum : sum) / cnt;
                    res.value = (sum < 0) ? -mag : mag;
                    arg = -1;
                end
            end
            else
                arg = -1;
        end
        res.argmax = arg[ARG_W-1:0];
        res.count = cnt[COUNT_W-1:0];
        res.out_h = oh[POS_W-1:0];
        res.out_w = ow[POS_W-1:0];
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // compare one accepted result beat with the oldest expectation
    task automatic check_beat();
        pool_result_t want;
        if (pending_results.size() == 0)
        begin
            error_count++;
            $display("[%0t] result beat with no expectation waiting", $time);
            return;
        end
        want = pending_results.pop_front();
        beats_checked++;
        if (rsp_ch.pooled_value !== want.value)
            report_mismatch("pooled_value", rsp_ch.pooled_value, want.value);
        if (rsp_ch.argmax_index !== want.argmax)
            report_mismatch("argmax_index", rsp_ch.argmax_index, want.argmax);
        if (rsp_ch.window_count !== want.count)
            report_mismatch("window_count", rsp_ch.window_count, want.count);
        if (rsp_ch.in_range !== want.in_range)
            report_mismatch("in_range", rsp_ch.in_range, want.in_range);
        if (rsp_ch.out_height !== want.out_h)
            report_mismatch("out_height", rsp_ch.out_height, want.out_h);
        if (rsp_ch.out_width !== want.out_w)
            report_mismatch("out_width", rsp_ch.out_width, want.out_w);
    endtask

    // result side: checks beats and stalls at random or on a long hold
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                check_beat();
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // send one beat, with a random gap first, and record its expectation
    task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                             logic [15:0] pix);
        pool_result_t res;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.row <= r;
        req_ch.col <= c;
        req_ch.pixel <= pix;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_pool(op, r, c, pix, res);
        pending_results.push_back(res);
        items_sent++;
        if (op == pool2d_pkg::OP_MAX)
            max_queries++;
        if (op == pool2d_pkg::OP_AVG)
            avg_queries++;
    endtask

    // wait until every result is back and the unit has settled
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic apply_config(int kh, int kw, int sr, int sc, int pr, int pc, int ih, int iw);
        int vals [8];
        vals = '{kh, kw, sr, sc, pr, pc, ih, iw};
        wait_idle();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= CFG_DAT_W'(vals[i]);
            @(posedge clk);
            case (i)
                pool2d_pkg::REG_KERNEL_H, pool2d_pkg::REG_KERNEL_W,
                pool2d_pkg::REG_STRIDE_R, pool2d_pkg::REG_STRIDE_C:
                    reg_file[i] = vals[i] & 32'h1f;
                pool2d_pkg::REG_PAD_R, pool2d_pkg::REG_PAD_C:
                    reg_file[i] = vals[i] & 32'hf;
                default:
                    reg_file[i] = vals[i] & 32'h7f;
            endcase
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(-$urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    // every pixel of the current plane gets a value before any query
    task automatic fill_image();
        int kh, kw, sr, sc, pr, pc, ih, iw, oh, ow;
        calc_geometry(kh, kw, sr, sc, pr, pc, ih, iw, oh, ow);
        for (int r = 0; r < ih; r++)
            for (int c = 0; c < iw; c++)
                if (!img_written[r*STORE_W + c])
                    send_item(pool2d_pkg::OP_WRITE, POS_W'(r), POS_W'(c), rand_pixel());
    endtask

    // random mix: mostly in-range queries, some writes, misses and no-ops
    task automatic run_random(int n);
        int kh, kw, sr, sc, pr, pc, ih, iw, oh, ow;
        int pick, r, c;
        calc_geometry(kh, kw, sr, sc, pr, pc, ih, iw, oh, ow);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_item(pool2d_pkg::OP_WRITE, POS_W'($urandom_range(0, ih - 1)),
                          POS_W'($urandom_range(0, iw - 1)), rand_pixel());
            else if (pick < 16)
                send_item(pool2d_pkg::OP_WRITE, POS_W'($urandom_range(0, 127)),
                          POS_W'($urandom_range(STORE_W, 127)), rand_pixel());
            else if (pick < 20)
                send_item(OP_NOP, POS_W'($urandom), POS_W'($urandom), 16'($urandom));
            else
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    r = $urandom_range(0, 127);
                    c = $urandom_range(0, 127);
                end
                else
                begin
                    r = $urandom_range(0, oh);
                    c = $urandom_range(0, ow);
                end
                send_item($urandom_range(0, 1) ? pool2d_pkg::OP_MAX : pool2d_pkg::OP_AVG,
                          POS_W'(r), POS_W'(c), 16'($urandom));
            end
        end
    endtask

    // defaults after reset, pixel extremes, ties, misses and ignored writes
    task automatic test_reset_defaults();
        send_item(pool2d_pkg::OP_WRITE, 7'd0, 7'd0, 16'h7fff);
        send_item(pool2d_pkg::OP_WRITE, 7'd0, 7'd1, 16'h8000);
        send_item(pool2d_pkg::OP_WRITE, 7'd1, 7'd0, 16'h7fff);
        send_item(pool2d_pkg::OP_WRITE, 7'd1, 7'd1, 16'h0000);
        send_item(pool2d_pkg::OP_MAX, 7'd0, 7'd0, 16'hffff);
        send_item(pool2d_pkg::OP_AVG, 7'd0, 7'd0, 16'h0000);
        send_item(pool2d_pkg::OP_WRITE, 7'd0, 7'd0, 16'h8000);
        send_item(pool2d_pkg::OP_WRITE, 7'd1, 7'd0, 16'h8000);
        send_item(pool2d_pkg::OP_MAX, 7'd0, 7'd0, 16'h0000);
        send_item(pool2d_pkg::OP_AVG, 7'd0, 7'd0, 16'h0000);
        send_item(pool2d_pkg::OP_MAX, 7'd32, 7'd0, 16'h0000);
        send_item(pool2d_pkg::OP_AVG, 7'd0, 7'd127, 16'h0000);
        send_item(pool2d_pkg::OP_MAX, 7'd127, 7'd127, 16'h0000);
        send_item(OP_NOP, 7'd0, 7'd0, 16'h1234);
        send_item(pool2d_pkg::OP_WRITE, 7'd64, 7'd0, 16'h5555);
        send_item(pool2d_pkg::OP_WRITE, 7'd0, 7'd127, 16'haaaa);
        send_item(pool2d_pkg::OP_MAX, 7'd0, 7'd0, 16'h0000);
    endtask

    // stride past the image leaves clipped-empty windows
    task automatic test_empty_windows();
        apply_config(1, 1, 16, 16, 0, 0, 3, 3);
        fill_image();
        send_item(pool2d_pkg::OP_MAX, 7'd1, 7'd1, 16'h0000);
        send_item(pool2d_pkg::OP_AVG, 7'd1, 7'd0, 16'h0000);
        send_item(pool2d_pkg::OP_MAX, 7'd0, 7'd0, 16'h0000);
        send_item(pool2d_pkg::OP_AVG, 7'd0, 7'd1, 16'h0000);
        run_random(20);
    endtask

    // largest kernel with the largest padding
    task automatic test_large_kernel();
        apply_config(16, 16, 1, 1, 15, 15, 16, 16);
        fill_image();
        send_item(pool2d_pkg::OP_MAX, 7'd15, 7'd15, 16'h0000);
        send_item(pool2d_pkg::OP_AVG, 7'd15, 7'd15, 16'h0000);
        send_item(pool2d_pkg::OP_AVG, 7'd0, 7'd30, 16'h0000);
        run_random(20);
    endtask

    // long result stall while items keep coming
    task automatic test_backpressure();
        apply_config(3, 2, 2, 3, 1, 1, 7, 9);
        fill_image();
        hold_request = 400;
        run_random(40);
    endtask

    // single row and single column planes across the full store
    task automatic test_edge_strips();
        apply_config(2, 3, 1, 2, 1, 5, 64, 1);
        fill_image();
        run_random(15);
        apply_config(1, 5, 1, 1, 0, 4, 1, 64);
        fill_image();
        run_random(15);
    endtask

    // register values outside their legal range
    task automatic test_out_of_range_regs();
        apply_config(31, 0, 0, 31, 15, 3, 127, 0);
        fill_image();
        run_random(15);
        apply_config(0, 17, 17, 0, 0, 15, 0, 65);
        fill_image();
        run_random(15);
    endtask

    task automatic test_mixed();
        apply_config(4, 4, 3, 3, 2, 1, 12, 10);
        fill_image();
        run_random(25);
    endtask

    // back-to-back beats with no gaps and no stalls
    task automatic test_streaming();
        apply_config(2, 2, 2, 2, 0, 0, 6, 6);
        quiet = 1'b1;
        fill_image();
        run_random(40);
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.opcode = pool2d_pkg::OP_WRITE;
        req_ch.row = '0;
        req_ch.col = '0;
        req_ch.pixel = '0;
        reg_file = '{2, 2, 2, 2, 0, 0, 64, 64};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_empty_windows();
        test_large_kernel();
        test_backpressure();
        test_edge_strips();
        test_out_of_range_regs();
        test_mixed();
        test_streaming();

        wait_idle();
        $display("sent %0d beats (%0d max, %0d average queries), checked %0d results",
                 items_sent, max_queries, avg_queries, beats_checked);
        $display("covered reset defaults, empty and full-size windows, strips, illegal regs");
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/pool2d_pkg.sv
rtl/core/pool2d_ifs.sv
rtl/core/pool2d_ctrl.sv
rtl/core/pool2d_dp.sv
rtl/core/pooling_2d_max_average_unit.sv
test/pooling_2d_max_average_unit_tb.sv
